// ===== src/sdcid_pkg.sv =====
// ----------------------------------------------------------------------------
// SD card identity decoder package
// Shared types and constants for the identity and capacity decoder.
// ----------------------------------------------------------------------------
package sdcid_pkg;

    localparam int unsigned IDX_W      = 6;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned CAP_W      = 42;
    localparam int unsigned SIZE_W     = 22;
    localparam int unsigned SHIFT_W    = 5;

    localparam logic [IDX_W-1:0] STREAM_LEN = 6'd36;
    localparam logic [IDX_W-1:0] ID_LEN     = 6'd18;
    localparam logic [IDX_W-1:0] LAST_IDX   = 6'd35;

    // Identity register byte positions.
    localparam logic [IDX_W-1:0] ID_MFR      = 6'd0;
    localparam logic [IDX_W-1:0] ID_OEM_HI   = 6'd1;
    localparam logic [IDX_W-1:0] ID_OEM_LO   = 6'd2;
    localparam logic [IDX_W-1:0] ID_PNM_0    = 6'd3;
    localparam logic [IDX_W-1:0] ID_PNM_4    = 6'd7;
    localparam logic [IDX_W-1:0] ID_REV      = 6'd8;
    localparam logic [IDX_W-1:0] ID_SER_0    = 6'd9;
    localparam logic [IDX_W-1:0] ID_SER_1    = 6'd10;
    localparam logic [IDX_W-1:0] ID_SER_2    = 6'd11;
    localparam logic [IDX_W-1:0] ID_SER_3    = 6'd12;
    localparam logic [IDX_W-1:0] ID_YEAR     = 6'd13;
    localparam logic [IDX_W-1:0] ID_YEAR_MON = 6'd14;

    // Specific-data register byte positions, counted from its first byte.
    localparam logic [IDX_W-1:0] SD_BLK_LEN  = 6'd5;
    localparam logic [IDX_W-1:0] SD_SIZE_0   = 6'd6;
    localparam logic [IDX_W-1:0] SD_SIZE_1   = 6'd7;
    localparam logic [IDX_W-1:0] SD_SIZE_2   = 6'd8;
    localparam logic [IDX_W-1:0] SD_MULT_0   = 6'd9;
    localparam logic [IDX_W-1:0] SD_MULT_1   = 6'd10;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MMC     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SDHC    = 3'd4;

    localparam logic [SHIFT_W-1:0] SDHC_SHIFT  = 5'd19;
    localparam logic [SHIFT_W-1:0] SHIFT_BIAS  = 5'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [KIND_W-1:0] kind_out;
        logic [7:0]       manufacturer;
        logic [15:0]      oem_id;
        logic [39:0]      product_name;
        logic [7:0]       revision;
        logic [31:0]      serial;
        logic [11:0]      year_code;
        logic [3:0]       month;
        logic [CAP_W-1:0] capacity_bytes;
    } t_out;

    typedef struct packed {
        logic [7:0]        data;
        logic [IDX_W-1:0]  idx;
        logic              first;
        logic [KIND_W-1:0] kind;
    } t_op;

endpackage

// ===== src/sdcid_front.sv =====
// ----------------------------------------------------------------------------
// SD card identity decoder front end
// Accepts bytes, tracks the stream position and queues positioned bytes.
// ----------------------------------------------------------------------------
module sdcid_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  sdcid_pkg::t_in                     i_in,
    input  logic [sdcid_pkg::KIND_W-1:0]       i_kind,
    input  logic                               i_q_full,
    output logic                               o_push,
    output sdcid_pkg::t_op                     o_op
);

    logic [sdcid_pkg::IDX_W-1:0] r_count;
    logic [sdcid_pkg::IDX_W-1:0] n_count;
    logic [sdcid_pkg::IDX_W-1:0] idx;
    logic                        accept;
    logic                        drop;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign idx     = i_in.first ? '0 : r_count;
    assign drop    = (idx >= sdcid_pkg::STREAM_LEN);
    assign o_push  = accept && !drop;

    assign o_op.data  = i_in.data_byte;
    assign o_op.idx   = idx;
    assign o_op.first = i_in.first;
    assign o_op.kind  = i_kind;

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== src/sdcid_queue.sv =====
// ----------------------------------------------------------------------------
// SD card identity decoder queue
// Two-entry queue that decouples the front end from the decode stage.
// ----------------------------------------------------------------------------
module sdcid_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sdcid_pkg::t_op i_op,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output sdcid_pkg::t_op o_op
);

    sdcid_pkg::t_op r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic           n_wptr;
    logic           n_rptr;
    logic [1:0]     n_count;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (do_pop) begin
            n_rptr = !r_rptr;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/sdcid_back.sv =====
// ----------------------------------------------------------------------------
// SD card identity decoder back end
// Captures register fields, computes capacity and holds the result register.
// ----------------------------------------------------------------------------
module sdcid_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sdcid_pkg::t_op  i_op,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output sdcid_pkg::t_out o_out
);

    logic [7:0]                     r_mfr,  n_mfr;
    logic [15:0]                    r_oem,  n_oem;
    logic [39:0]                    r_pnm,  n_pnm;
    logic [7:0]                     r_rev,  n_rev;
    logic [31:0]                    r_ser,  n_ser;
    logic [11:0]                    r_year, n_year;
    logic [3:0]                     r_mon,  n_mon;
    logic [sdcid_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [3:0]                     r_blk,  n_blk;
    logic [2:0]                     r_mult, n_mult;
    logic [sdcid_pkg::CAP_W-1:0]    r_cap,  n_cap;
    logic                           r_out_valid, n_out_valid;
    sdcid_pkg::t_out                r_out,  n_out;

    logic                           last;
    logic                           known;
    logic [sdcid_pkg::IDX_W-1:0]    spec;
    logic [7:0]                     d;
    logic [sdcid_pkg::SIZE_W-1:0]   cap_size;
    logic [2:0]                     cap_mult;
    logic [sdcid_pkg::SIZE_W:0]     size_inc;
    logic [sdcid_pkg::SHIFT_W-1:0]  shamt;
    logic [sdcid_pkg::CAP_W-1:0]    cap_calc;

    assign last  = (i_op.idx == sdcid_pkg::LAST_IDX);
    assign o_pop = i_q_valid && (!last || !r_out_valid || i_ready);
    assign spec  = i_op.idx - sdcid_pkg::ID_LEN;
    assign d     = i_op.data;
    assign known = (i_op.kind >= sdcid_pkg::KIND_MMC) && (i_op.kind <= sdcid_pkg::KIND_SDHC);

    // The size and multiplier as they stand once the completing byte is merged in.
    assign cap_size = (i_op.kind == sdcid_pkg::KIND_SDHC) ?
                      {r_size[21:8], r_size[7:0] | d} : r_size;
    assign cap_mult = {r_mult[2:1], r_mult[0] | d[7]};

    assign size_inc = {1'b0, cap_size} + 1'b1;
    assign cap_calc = {{(sdcid_pkg::CAP_W - sdcid_pkg::SIZE_W - 1){1'b0}}, size_inc} << shamt;

    always_comb begin
        if (i_op.kind == sdcid_pkg::KIND_SDHC) begin
            shamt = sdcid_pkg::SDHC_SHIFT;
        end else begin
            shamt = {2'b00, cap_mult} + {1'b0, r_blk} + sdcid_pkg::SHIFT_BIAS;
        end
    end

    always_comb begin
        n_mfr  = r_mfr;
        n_oem  = r_oem;
        n_pnm  = r_pnm;
        n_rev  = r_rev;
        n_ser  = r_ser;
        n_year = r_year;
        n_mon  = r_mon;
        n_size = r_size;
        n_blk  = r_blk;
        n_mult = r_mult;
        n_cap  = r_cap;
        if (o_pop) begin
            if (i_op.first) begin
                n_ser  = '0;
                n_size = '0;
                n_blk  = '0;
                n_mult = '0;
            end
            if (i_op.idx < sdcid_pkg::ID_LEN) begin
                priority if (i_op.idx == sdcid_pkg::ID_MFR) begin
                    n_mfr = d;
                end else if (i_op.idx <= sdcid_pkg::ID_OEM_LO) begin
                    n_oem = {r_oem[7:0], d};
                end else if (i_op.idx <= sdcid_pkg::ID_PNM_4) begin
                    n_pnm = {r_pnm[31:0], d};
                end else if (i_op.idx == sdcid_pkg::ID_REV) begin
                    n_rev = d;
                end else if (i_op.idx == sdcid_pkg::ID_SER_0) begin
                    n_ser[31:24] = n_ser[31:24] | d;
                end else if (i_op.idx == sdcid_pkg::ID_SER_1) begin
                    n_ser[23:16] = n_ser[23:16] | d;
                end else if (i_op.idx == sdcid_pkg::ID_SER_2) begin
                    n_ser[15:8] = n_ser[15:8] | d;
                end else if (i_op.idx == sdcid_pkg::ID_SER_3) begin
                    n_ser[7:0] = n_ser[7:0] | d;
                end else if (i_op.idx == sdcid_pkg::ID_YEAR) begin
                    n_year = {d, 4'h0};
                end else if (i_op.idx == sdcid_pkg::ID_YEAR_MON) begin
                    n_year = r_year | {8'h00, d[7:4]};
                    n_mon  = d[3:0];
                end else begin
                    n_mfr = r_mfr;
                end
            end else if (i_op.kind == sdcid_pkg::KIND_SDHC) begin
                priority if (spec == sdcid_pkg::SD_SIZE_1) begin
                    n_size = {8'h00, d[5:0], 8'h00};
                end else if (spec == sdcid_pkg::SD_SIZE_2) begin
                    n_size = {n_size[13:8], n_size[7:0] | d, 8'h00};
                end else if (spec == sdcid_pkg::SD_MULT_0) begin
                    n_size = {n_size[21:8], n_size[7:0] | d};
                    n_cap  = cap_calc;
                end else begin
                    n_cap = r_cap;
                end
            end else begin
                priority if (spec == sdcid_pkg::SD_BLK_LEN) begin
                    n_blk = d[3:0];
                end else if (spec == sdcid_pkg::SD_SIZE_0) begin
                    n_size = {12'h000, d[1:0], 8'h00};
                end else if (spec == sdcid_pkg::SD_SIZE_1) begin
                    n_size = {n_size[19:8], n_size[7:0] | d, 2'b00};
                end else if (spec == sdcid_pkg::SD_SIZE_2) begin
                    n_size = {n_size[21:2], n_size[1:0] | d[7:6]};
                end else if (spec == sdcid_pkg::SD_MULT_0) begin
                    n_mult = {d[1:0], 1'b0};
                end else if (spec == sdcid_pkg::SD_MULT_1) begin
                    n_mult = {n_mult[2:1], n_mult[0] | d[7]};
                    n_cap  = cap_calc;
                end else begin
                    n_cap = r_cap;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop && last) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.status   = !known;
            n_out.kind_out = i_op.kind;
            if (known) begin
                n_out.manufacturer   = n_mfr;
                n_out.oem_id         = n_oem;
                n_out.product_name   = n_pnm;
                n_out.revision       = n_rev;
                n_out.serial         = n_ser;
                n_out.year_code      = n_year;
                n_out.month          = n_mon;
                n_out.capacity_bytes = n_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfr       <= '0;
            r_oem       <= '0;
            r_pnm       <= '0;
            r_rev       <= '0;
            r_ser       <= '0;
            r_year      <= '0;
            r_mon       <= '0;
            r_size      <= '0;
            r_blk       <= '0;
            r_mult      <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mfr       <= n_mfr;
            r_oem       <= n_oem;
            r_pnm       <= n_pnm;
            r_rev       <= n_rev;
            r_ser       <= n_ser;
            r_year      <= n_year;
            r_mon       <= n_mon;
            r_size      <= n_size;
            r_blk       <= n_blk;
            r_mult      <= n_mult;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== src/sd_card_id_and_capacity_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// SD card identity and capacity decoder
// The last byte goes through the queue and then into the result register.
// Throughput: one byte per cycle; the last byte waits while a result is unread.
// Reset is synchronous and active low and clears the card kind, the byte
// count and all captured fields to zero.
// ----------------------------------------------------------------------------
module sd_card_id_and_capacity_decoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  sdcid_pkg::t_in                 i_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output sdcid_pkg::t_out                o_out,
    input  logic                           i_cfg_we,
    input  logic [sdcid_pkg::KIND_W-1:0]   i_cfg_data
);

    logic [sdcid_pkg::KIND_W-1:0] r_card_kind;
    logic                         q_full;
    logic                         q_valid;
    logic                         push;
    logic                         pop;
    sdcid_pkg::t_op               push_op;
    sdcid_pkg::t_op               head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_kind <= sdcid_pkg::KIND_UNKNOWN;
        end else if (i_cfg_we) begin
            r_card_kind <= i_cfg_data;
        end
    end

    sdcid_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_in     (i_in),
        .i_kind   (r_card_kind),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (push_op)
    );

    sdcid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_op    (head_op)
    );

    sdcid_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );

endmodule
